>>> design/software_timer_bank_core_assert.svh
// ----------------------------------------------------------------------------
// software timer bank assertion macros
// shared assertion wrappers, clocked on i_clk and held off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_BANK_CORE_ASSERT_SVH
`define SOFTWARE_TIMER_BANK_CORE_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define STB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// implication form, antecedent and consequent given apart
`define STB_ASSERT_IMP(lbl, ante, cons, msg) \
    `STB_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication form
`define STB_ASSERT_NXT(lbl, ante, cons, msg) \
    `STB_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

>>> design/stb_pkg.sv
// ----------------------------------------------------------------------------
// software timer bank package
// word types, command codes, timer states and controller interface structs
// ----------------------------------------------------------------------------
package stb_pkg;

    localparam int NUM_TIMERS_DEF = 16;

    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_START   = 3'd1;
    localparam logic [2:0] MODE_STOP    = 3'd2;
    localparam logic [2:0] MODE_RESTART = 3'd3;
    localparam logic [2:0] MODE_PAUSE   = 3'd4;
    localparam logic [2:0] MODE_RESUME  = 3'd5;
    localparam logic [2:0] MODE_READ    = 3'd6;

    localparam logic [1:0] ST_STOPPED = 2'd0;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_PAUSED  = 2'd2;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  timer_index;
        logic [31:0] start_value;
    } t_in_word;

    typedef struct packed {
        logic [3:0]  timer_index_out;
        logic [31:0] count_value;
        logic [1:0]  run_state;
        logic        expired_flag;
        logic [15:0] expired_mask;
    } t_out_word;

    typedef struct packed {
        logic [31:0] count;
        logic [1:0]  state;
        logic        flag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic start;
        logic cmd_exec;
        logic tick_exec;
        logic out_load;
    } t_ctl_cmd;

    typedef struct packed {
        logic is_tick;
        logic tick_last;
    } t_ctl_stat;

endpackage

>>> design/stb_ram.sv
// ----------------------------------------------------------------------------
// stb_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module stb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/stb_datapath.sv
// ----------------------------------------------------------------------------
// stb_datapath
// timer store, per-entry valid bits, tick walk counter and result registers
// ----------------------------------------------------------------------------
module stb_datapath #(
    parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stb_pkg::t_in_word  i_in_word,
    input  stb_pkg::t_ctl_cmd  i_cmd,
    output stb_pkg::t_ctl_stat o_stat,
    output stb_pkg::t_out_word o_out_word
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_TIMERS - 1);

    logic [NUM_TIMERS-1:0] r_vld;
    stb_pkg::t_in_word     r_item;
    logic                  r_idx_ok;
    logic [IDX_W-1:0]      r_cnt;
    logic                  r_rd_vld;
    stb_pkg::t_out_word    r_res;
    stb_pkg::t_out_word    r_out;

    logic                  in_idx_ok;
    logic [IDX_W-1:0]      in_addr;
    logic [IDX_W-1:0]      item_addr;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  rd_ok;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [stb_pkg::ENTRY_W-1:0] rd_data;
    stb_pkg::t_entry       cur;
    stb_pkg::t_entry       cmd_new;
    stb_pkg::t_entry       tick_new;
    stb_pkg::t_entry       wr_entry;
    logic [31:0]           dec;
    logic                  hit;

    assign in_idx_ok = 32'(i_in_word.timer_index) < 32'(NUM_TIMERS);
    assign in_addr   = IDX_W'(i_in_word.timer_index);
    assign item_addr = IDX_W'(r_item.timer_index);

    // read side: first entry or addressed entry at accept, next entry while walking
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        rd_ok   = 1'b0;
        if (i_cmd.start) begin
            rd_en   = 1'b1;
            rd_addr = i_in_word.mode == stb_pkg::MODE_TICK ? '0 : in_addr;
            rd_ok   = i_in_word.mode == stb_pkg::MODE_TICK ? 1'b1 : in_idx_ok;
        end else if (i_cmd.tick_exec && r_cnt != LAST) begin
            rd_en   = 1'b1;
            rd_addr = r_cnt + IDX_W'(1);
            rd_ok   = 1'b1;
        end
    end

    // an entry never written since reset reads as a cleared timer
    assign cur = r_rd_vld ? stb_pkg::t_entry'(rd_data) : '0;

    always_comb begin
        cmd_new = cur;
        case (r_item.mode)
            stb_pkg::MODE_START: begin
                if (cur.state == stb_pkg::ST_STOPPED && r_item.start_value != '0) begin
                    cmd_new = '{count: r_item.start_value, state: stb_pkg::ST_RUNNING,
                                flag: 1'b0};
                end
            end
            stb_pkg::MODE_STOP: begin
                cmd_new = '0;
            end
            stb_pkg::MODE_RESTART: begin
                if (r_item.start_value != '0) begin
                    cmd_new = '{count: r_item.start_value, state: stb_pkg::ST_RUNNING,
                                flag: 1'b0};
                end else begin
                    cmd_new = '0;
                end
            end
            stb_pkg::MODE_PAUSE: begin
                if (cur.state == stb_pkg::ST_RUNNING) begin
                    cmd_new.state = stb_pkg::ST_PAUSED;
                end
            end
            stb_pkg::MODE_RESUME: begin
                if (cur.state == stb_pkg::ST_PAUSED) begin
                    cmd_new.state = stb_pkg::ST_RUNNING;
                end
            end
            default: begin
                cmd_new = cur;
            end
        endcase
    end

    assign dec = cur.count - 32'd1;

    always_comb begin
        tick_new = cur;
        if (cur.state == stb_pkg::ST_RUNNING && !cur.flag) begin
            tick_new.count = dec;
            if (dec == '0) begin
                tick_new.flag  = 1'b1;
                tick_new.state = stb_pkg::ST_STOPPED;
            end
        end
    end

    assign hit      = r_idx_ok && (32'(r_cnt) == 32'(r_item.timer_index));
    assign wr_en    = i_cmd.tick_exec || (i_cmd.cmd_exec && r_idx_ok);
    assign wr_addr  = i_cmd.tick_exec ? r_cnt : item_addr;
    assign wr_entry = i_cmd.tick_exec ? tick_new : cmd_new;

    stb_ram #(
        .WIDTH (stb_pkg::ENTRY_W),
        .DEPTH (NUM_TIMERS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_entry),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_vld <= rd_ok ? r_vld[rd_addr] : 1'b0;
        end
        if (i_cmd.start) begin
            r_item   <= i_in_word;
            r_idx_ok <= in_idx_ok;
            r_cnt    <= '0;
            r_res    <= '{timer_index_out: i_in_word.timer_index, default: '0};
        end
        if (i_cmd.cmd_exec && r_idx_ok) begin
            r_res.count_value  <= cmd_new.count;
            r_res.run_state    <= cmd_new.state;
            r_res.expired_flag <= cmd_new.flag;
        end
        if (i_cmd.tick_exec) begin
            r_cnt <= r_cnt + IDX_W'(1);
            if (hit) begin
                r_res.count_value  <= tick_new.count;
                r_res.run_state    <= tick_new.state;
                r_res.expired_flag <= tick_new.flag;
            end
            // only the first sixteen timers are reported in the mask
            if (32'(r_cnt) < 32'd16 && tick_new.flag && !cur.flag) begin
                r_res.expired_mask[4'(r_cnt)] <= 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_stat.is_tick   = i_in_word.mode == stb_pkg::MODE_TICK;
    assign o_stat.tick_last = r_cnt == LAST;
    assign o_out_word       = r_out;

endmodule

>>> design/stb_ctrl.sv
// ----------------------------------------------------------------------------
// stb_ctrl
// item sequencer: accept, command update or tick walk, result hand-off
// ----------------------------------------------------------------------------
module stb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  stb_pkg::t_ctl_stat i_stat,
    output stb_pkg::t_ctl_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMD  = 2'd1;
    localparam logic [1:0] S_TICK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = i_stat.is_tick ? S_TICK : S_CMD;
                end
            end
            S_CMD: begin
                o_cmd.cmd_exec = 1'b1;
                n_state        = S_DONE;
            end
            S_TICK: begin
                o_cmd.tick_exec = 1'b1;
                if (i_stat.tick_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = o_cmd.out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`include "software_timer_bank_core_assert.svh"

    `STB_ASSERT_NXT(a_cmd_one_cycle, r_state == S_CMD, r_state == S_DONE, "command update not followed by hand-off")
    `STB_ASSERT_NXT(a_tick_ends, r_state == S_TICK && i_stat.tick_last, r_state == S_DONE, "tick walk did not end after last entry")
    `STB_ASSERT_NXT(a_load_shows, o_cmd.out_load, o_out_valid, "loaded result not presented")
    `STB_ASSERT_IMP(a_load_free, o_cmd.out_load, !r_out_valid || i_out_ready, "result loaded over a pending word")

endmodule

>>> design/software_timer_bank_core.sv
// command items (start, stop, restart, pause, resume, read): accept, command update, result hand-off
// tick items: a walk over all NUM_TIMERS entries, one store entry read and written back per cycle
// one item in flight; the next is taken once the result sits in the output register
// synchronous active-low reset clears control and the per-entry valid bits, so every
// timer reads as stopped with a zero count at once; no clearing pass
// ----------------------------------------------------------------------------
// software_timer_bank_core
// bank of one-shot down-counting timers driven by tick and command words
// ----------------------------------------------------------------------------
module software_timer_bank_core #(
    parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  stb_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output stb_pkg::t_out_word o_out_word
);

    stb_pkg::t_ctl_cmd  ctl_cmd;
    stb_pkg::t_ctl_stat ctl_stat;

    stb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (ctl_stat),
        .o_cmd       (ctl_cmd)
    );

    stb_datapath #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cmd      (ctl_cmd),
        .o_stat     (ctl_stat),
        .o_out_word (o_out_word)
    );

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// software timer bank testbench
// a queue of command and tick words feeds a clocked driver with random gaps;
// a clocked monitor predicts each report from its own copy of the timer bank
// and compares it field by field with what the block returns
// ----------------------------------------------------------------------------
module tb;

    localparam int          NUM_T       = stb_pkg::NUM_TIMERS_DEF;
    localparam logic [2:0]  MODE_SPARE  = 3'd7;
    localparam int          RANDOM_CMDS = 950;
    localparam int          IDLE_LIMIT  = 2000;
    localparam int          TAIL_CYCLES = 40;
    localparam int          HOLD_CYCLES = 400;
    localparam int          HOLD_AT     = 150;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    stb_pkg::t_in_word  i_in_word;
    logic               o_out_valid;
    logic               i_out_ready;
    stb_pkg::t_out_word o_out_word;

    software_timer_bank_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // shadow copy of the timer bank
    logic [31:0] shadow_count [NUM_T];
    logic [1:0]  shadow_state [NUM_T];
    logic        shadow_flag  [NUM_T];

    stb_pkg::t_in_word  pending_words [$];
    stb_pkg::t_out_word expected_reports [$];

    int  words_total;
    int  words_accepted;
    int  reports_checked;
    int  ticks_seen;
    int  expiries_seen;
    int  errors;
    int  idle_cycles;
    logic in_taken;
    logic out_taken;

    // driver and receiver pacing
    int  send_gap;
    int  send_calm;
    int  recv_gap;
    int  recv_calm;
    int  recv_count;

    always #5 i_clk = ~i_clk;

    function automatic void clear_timer(int unsigned t);
        shadow_count[t] = '0;
        shadow_state[t] = stb_pkg::ST_STOPPED;
        shadow_flag[t]  = 1'b0;
    endfunction

    function automatic void arm_timer(int unsigned t, logic [31:0] v);
        if (shadow_state[t] == stb_pkg::ST_STOPPED && v != 0) begin
            shadow_count[t] = v;
            shadow_state[t] = stb_pkg::ST_RUNNING;
            shadow_flag[t]  = 1'b0;
        end
    endfunction

    function automatic stb_pkg::t_out_word predict_report(stb_pkg::t_in_word w);
        stb_pkg::t_out_word r;
        logic [15:0]        mask;
        int unsigned        t;
        int unsigned        idx;
        mask = '0;
        idx  = 32'(w.timer_index);
        case (w.mode)
            stb_pkg::MODE_TICK: begin
                for (t = 0; t < NUM_T; t++) begin
                    if (shadow_state[t] == stb_pkg::ST_RUNNING && !shadow_flag[t]) begin
                        shadow_count[t] = shadow_count[t] - 32'd1;
                        if (shadow_count[t] == 0) begin
                            shadow_flag[t]  = 1'b1;
                            shadow_state[t] = stb_pkg::ST_STOPPED;
                            if (t < 16) mask[t] = 1'b1;
                        end
                    end
                end
            end
            stb_pkg::MODE_START: begin
                arm_timer(idx, w.start_value);
            end
            stb_pkg::MODE_STOP: begin
                clear_timer(idx);
            end
            stb_pkg::MODE_RESTART: begin
                clear_timer(idx);
                arm_timer(idx, w.start_value);
            end
            stb_pkg::MODE_PAUSE: begin
                if (shadow_state[idx] == stb_pkg::ST_RUNNING) begin
                    shadow_state[idx] = stb_pkg::ST_PAUSED;
                end
            end
            stb_pkg::MODE_RESUME: begin
                if (shadow_state[idx] == stb_pkg::ST_PAUSED) begin
                    shadow_state[idx] = stb_pkg::ST_RUNNING;
                end
            end
            default: begin
            end
        endcase
        r.timer_index_out = w.timer_index;
        r.count_value     = shadow_count[idx];
        r.run_state       = shadow_state[idx];
        r.expired_flag    = shadow_flag[idx];
        r.expired_mask    = mask;
        return r;
    endfunction

    task automatic queue_word(logic [2:0] mode, logic [3:0] idx, logic [31:0] val);
        stb_pkg::t_in_word w;
        w.mode        = mode;
        w.timer_index = idx;
        w.start_value = val;
        pending_words.push_back(w);
    endtask

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t tb: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    // monitor: results first, since a new word may be taken at the same edge
    always @(posedge i_clk) begin
        stb_pkg::t_out_word want;
        if (!i_rst_n) begin
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
        end else begin
            in_taken  <= i_in_valid && o_in_ready;
            out_taken <= o_out_valid && i_out_ready;
            if (o_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    errors++;
                    $display("%0t tb: unexpected report, expected none, got %0h",
                             $time, o_out_word);
                end else begin
                    want = expected_reports.pop_front();
                    check_field("timer_index_out", 32'(want.timer_index_out),
                                32'(o_out_word.timer_index_out));
                    check_field("count_value", want.count_value, o_out_word.count_value);
                    check_field("run_state", 32'(want.run_state),
                                32'(o_out_word.run_state));
                    check_field("expired_flag", 32'(want.expired_flag),
                                32'(o_out_word.expired_flag));
                    check_field("expired_mask", 32'(want.expired_mask),
                                32'(o_out_word.expired_mask));
                    reports_checked++;
                end
            end
            if (i_in_valid && o_in_ready) begin
                want = predict_report(i_in_word);
                expected_reports.push_back(want);
                words_accepted++;
                if (i_in_word.mode == stb_pkg::MODE_TICK) ticks_seen++;
                expiries_seen += $countones(want.expired_mask);
            end
        end
    end

    // driver
    always @(negedge i_clk) begin
        logic v;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            v = i_in_valid;
            if (v && in_taken) begin
                v = 1'b0;
                if (send_calm > 0) begin
                    send_calm--;
                    send_gap = 0;
                end else begin
                    if ($urandom_range(0, 19) == 0) send_calm = 30;
                    send_gap = $urandom_range(0, 15);
                end
            end
            if (!v) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_words.size() > 0) begin
                    i_in_word <= pending_words.pop_front();
                    v = 1'b1;
                end
            end
            i_in_valid <= v;
        end
    end

    // receiver, with one long hold-off so the block backs up
    always @(negedge i_clk) begin
        logic r;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            r = i_out_ready;
            if (r && out_taken) begin
                r = 1'b0;
                recv_count++;
                if (recv_count == HOLD_AT) begin
                    recv_gap = HOLD_CYCLES;
                end else if (recv_calm > 0) begin
                    recv_calm--;
                    recv_gap = 0;
                end else begin
                    if ($urandom_range(0, 19) == 0) recv_calm = 30;
                    recv_gap = $urandom_range(0, 15);
                end
            end
            if (!r) begin
                if (recv_gap > 0) recv_gap--;
                else r = 1'b1;
            end
            i_out_ready <= r;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t tb: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int          n;
        int unsigned pick;
        logic [2:0]  mode;
        logic [31:0] val;
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_in_word       = '0;
        i_out_ready     = 1'b0;
        words_accepted  = 0;
        reports_checked = 0;
        ticks_seen      = 0;
        expiries_seen   = 0;
        errors          = 0;
        idle_cycles     = 0;
        send_gap        = 0;
        send_calm       = 0;
        recv_gap        = 0;
        recv_calm       = 0;
        recv_count      = 0;
        for (n = 0; n < NUM_T; n++) clear_timer(n);

        // directed: reset state, ignored starts, pause and resume, expiries
        queue_word(stb_pkg::MODE_READ, 4'd0, 32'd0);
        queue_word(stb_pkg::MODE_START, 4'd3, 32'd0);
        queue_word(stb_pkg::MODE_START, 4'd3, 32'hFFFF_FFFF);
        queue_word(stb_pkg::MODE_START, 4'd3, 32'd5);
        queue_word(stb_pkg::MODE_TICK, 4'd3, 32'd0);
        queue_word(stb_pkg::MODE_PAUSE, 4'd3, 32'd0);
        queue_word(stb_pkg::MODE_TICK, 4'd3, 32'hFFFF_FFFF);
        queue_word(stb_pkg::MODE_PAUSE, 4'd3, 32'd0);
        queue_word(stb_pkg::MODE_RESUME, 4'd3, 32'd0);
        queue_word(stb_pkg::MODE_RESUME, 4'd3, 32'd0);
        queue_word(stb_pkg::MODE_STOP, 4'd3, 32'd0);
        queue_word(stb_pkg::MODE_RESTART, 4'd3, 32'd0);
        queue_word(stb_pkg::MODE_START, 4'd0, 32'd1);
        queue_word(stb_pkg::MODE_START, 4'd15, 32'd1);
        queue_word(stb_pkg::MODE_START, 4'd7, 32'd2);
        queue_word(stb_pkg::MODE_TICK, 4'd0, 32'd0);
        queue_word(stb_pkg::MODE_TICK, 4'd7, 32'd0);
        queue_word(stb_pkg::MODE_READ, 4'd15, 32'd0);
        queue_word(stb_pkg::MODE_START, 4'd15, 32'd3);
        queue_word(stb_pkg::MODE_RESTART, 4'd15, 32'd7);
        queue_word(MODE_SPARE, 4'd15, 32'h5555_AAAA);
        queue_word(stb_pkg::MODE_PAUSE, 4'd0, 32'd0);
        queue_word(stb_pkg::MODE_TICK, 4'd9, 32'd0);
        queue_word(stb_pkg::MODE_RESTART, 4'd3, 32'hFFFF_FFFF);
        queue_word(stb_pkg::MODE_STOP, 4'd15, 32'd0);

        // random: mostly ticks and short starts so timers run out often
        for (n = 0; n < RANDOM_CMDS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      mode = stb_pkg::MODE_TICK;
            else if (pick < 56) mode = stb_pkg::MODE_START;
            else if (pick < 66) mode = stb_pkg::MODE_RESTART;
            else if (pick < 71) mode = stb_pkg::MODE_STOP;
            else if (pick < 79) mode = stb_pkg::MODE_PAUSE;
            else if (pick < 87) mode = stb_pkg::MODE_RESUME;
            else if (pick < 96) mode = stb_pkg::MODE_READ;
            else                mode = MODE_SPARE;
            pick = $urandom_range(0, 9);
            if (pick == 0)     val = '0;
            else if (pick < 8) val = $urandom_range(1, 8);
            else               val = $urandom;
            queue_word(mode, 4'($urandom_range(0, 15)), val);
        end
        words_total = pending_words.size();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (words_accepted < words_total || expected_reports.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("tb: %0d words, %0d ticks, %0d timer expiries, %0d reports checked",
                 words_accepted, ticks_seen, expiries_seen, reports_checked);
        $display("tb: receiver held off once for %0d cycles, %0d mismatches",
                 HOLD_CYCLES, errors);
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+design
design/stb_pkg.sv
design/stb_ram.sv
design/stb_datapath.sv
design/stb_ctrl.sv
design/software_timer_bank_core.sv
test/tb.sv
